// File: hw/rtl/bb3_pkg.sv
// shared types and constants of the 3x3 box blur
package bb3_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int PIX_W     = 8;
    localparam int ROW_W     = 12;
    localparam int COL_W     = 11;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int LINE_W    = 2 * PIX_W;
    localparam int CSUM_W    = PIX_W + 2;
    localparam int SUM_W     = PIX_W + 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd2048;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd2048;

    // divide by 9 as multiply by ceil(2^16 / 9) and shift, exact for sums up to 9 * 255
    localparam int              RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_9  = 13'd7282;
    localparam int              RECIP_SHIFT = 16;
    localparam int              PROD_W      = SUM_W + RECIP_W;

    // result queue, depth a power of two
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
    } pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             last_of_item;
        logic             frame_done;
    } result_t;

    // per-pixel tag that travels with the pipeline
    typedef struct packed {
        logic             has_int;
        logic             has_bord;
        logic             done;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } meta_t;

    typedef struct packed {
        meta_t            meta;
        logic [PIX_W-1:0] mean;
        logic [PIX_W-1:0] pix;
    } entry_t;

endpackage

// File: hw/rtl/bb3_stream_if.sv
// valid/ready stream channel with a typed payload
interface bb3_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/bb3_line_store.sv
// two-line store in one synchronous ram, with write-to-read forwarding
module bb3_line_store #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]    rd_addr,
    input  logic                            wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
    input  logic [bb3_pkg::LINE_W-1:0]      wr_data,
    output logic [bb3_pkg::LINE_W-1:0]      rd_data
);
    import bb3_pkg::*;

    logic [LINE_W-1:0] line_mem [MAX_WIDTH];
    logic [LINE_W-1:0] rd_data_reg;
    logic [LINE_W-1:0] fwd_data_reg;
    logic              fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= line_mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // read and write of the same column at one edge: the ram returns stale data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_data_reg;

endmodule

// File: hw/rtl/bb3_window.sv
// 3x3 window kept as column sums, window sum and divide by nine
module bb3_window (
    input  logic                       clk,
    input  logic                       shift_en,
    input  logic [bb3_pkg::PIX_W-1:0]  up2,
    input  logic [bb3_pkg::PIX_W-1:0]  up1,
    input  logic [bb3_pkg::PIX_W-1:0]  pix,
    output logic [bb3_pkg::PIX_W-1:0]  mean
);
    import bb3_pkg::*;

    logic [CSUM_W-1:0] csum_reg [3];
    logic [CSUM_W-1:0] csum_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [PROD_W-1:0] prod;

    assign csum_next = CSUM_W'(up2) + CSUM_W'(up1) + CSUM_W'(pix);
    assign sum_next  = SUM_W'(csum_reg[0]) + SUM_W'(csum_reg[1]) + SUM_W'(csum_reg[2]);

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            csum_reg[0] <= csum_reg[1];
            csum_reg[1] <= csum_reg[2];
            csum_reg[2] <= csum_next;
        end
        sum_reg <= sum_next;
    end

    assign prod = PROD_W'(sum_reg) * PROD_W'(RECIP_9);
    assign mean = prod[RECIP_SHIFT +: PIX_W];

endmodule

// File: hw/rtl/bb3_out_fifo.sv
// result queue, one entry per pixel that has a result, unpacked into one or two results
module bb3_out_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  bb3_pkg::entry_t                push_entry,
    output logic [bb3_pkg::FIFO_CNT_W-1:0] count,
    bb3_stream_if.source                   results
);
    import bb3_pkg::*;

    entry_t                fifo_q [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic                  int_sent_reg;

    entry_t  head;
    result_t res;
    logic    show_int;
    logic    xfer;
    logic    pop;

    assign head     = fifo_q[rd_ptr_reg];
    assign show_int = head.meta.has_int && !int_sent_reg;

    always_comb
    begin
        if (show_int)
        begin
            res.pixel_out    = head.mean;
            res.out_row      = head.meta.row - ROW_W'(1);
            res.out_col      = head.meta.col - COL_W'(1);
            res.last_of_item = !head.meta.has_bord;
            res.frame_done   = !head.meta.has_bord && head.meta.done;
        end
        else
        begin
            res.pixel_out    = head.pix;
            res.out_row      = head.meta.row;
            res.out_col      = head.meta.col;
            res.last_of_item = 1'b1;
            res.frame_done   = head.meta.done;
        end
    end

    assign results.valid = (cnt_reg != '0);
    assign results.data  = res;
    assign xfer          = results.valid && results.ready;
    assign pop           = xfer && res.last_of_item;
    assign count         = cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_q[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
            int_sent_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + FIFO_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - FIFO_CNT_W'(1);
            end
            if (pop)
            begin
                int_sent_reg <= 1'b0;
            end
            else if (xfer)
            begin
                int_sent_reg <= 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/box_blur_3x3_core.sv
// top level of the streaming 3x3 box blur
//
// Pixels enter on the pixels channel in raster order, one per transfer; the
// block counts row and column itself. Results leave on the results channel,
// each with its row and column: a border pixel passes through unchanged,
// an interior pixel (r-1,c-1) carries the truncated mean of its 3x3
// neighborhood and is sent when pixel (r,c) arrives, ahead of the border
// result of (r,c) if there is one. last_of_item marks the last result of an
// input pixel, frame_done the last result of the frame.
// Throughput is one pixel per clock while pixels.ready is high; it is set by
// the single line-store ram, read at accept and written back in the next cycle.
// Over the last row, where most pixels give two results, the input slows as the
// queue fills. The first result of a pixel can transfer after the ram read, the
// column sum, the window sum and the write into the 8-entry result queue.
// A pixel that yields two results holds the queue head until both have gone.
// When the receiver stalls, the queue fills and pixels.ready drops as soon
// as queue entries plus pixels in flight reach the queue depth.
// Reset sets width and height to 2048 and the counters to zero; line store
// contents are not cleared and need not be. A configuration write restarts
// the frame at row 0, column 0.
module box_blur_3x3_core #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]      cfg_wdata,
    bb3_stream_if.sink                     pixels,
    bb3_stream_if.source                   results
);
    import bb3_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int EW     = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = (EW > CFG_W) ? EW : CFG_W;

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ADDR_W-1:0] col_reg;

    logic [CMP_W-1:0]  w_eff;
    logic [ROW_W-1:0]  h_eff;
    logic [CMP_W-1:0]  col_inc;
    logic [ROW_W:0]    row_inc;
    logic              last_col;
    logic              last_row;
    logic              interior;
    logic              border;
    logic              accept;
    meta_t             meta_in;

    // pipeline stages
    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    meta_t             s1_meta_reg;
    logic              s2_valid_reg;
    logic [PIX_W-1:0]  s2_pix_reg;
    meta_t             s2_meta_reg;
    logic              s3_valid_reg;
    logic [PIX_W-1:0]  s3_pix_reg;
    meta_t             s3_meta_reg;

    logic [LINE_W-1:0]     line_rd;
    logic [PIX_W-1:0]      up2;
    logic [PIX_W-1:0]      up1;
    logic [PIX_W-1:0]      mean;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W-1:0] inflight;
    logic                  push;
    entry_t                push_entry;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = CMP_W'(1);
        end
        else if (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH))
        begin
            w_eff = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CMP_W'(width_reg);
        end
    end

    assign h_eff    = (height_reg == '0) ? ROW_W'(1) : ROW_W'(height_reg);
    assign col_inc  = CMP_W'(col_reg) + CMP_W'(1);
    assign row_inc  = {1'b0, row_reg} + (ROW_W + 1)'(1);
    assign last_col = (col_inc == w_eff);
    assign last_row = (row_inc == {1'b0, h_eff});
    assign interior = (row_reg >= ROW_W'(2)) && (col_reg >= ADDR_W'(2));
    assign border   = (row_reg == '0) || (col_reg == '0) || last_row || last_col;

    assign meta_in.has_int  = interior;
    assign meta_in.has_bord = border;
    assign meta_in.done     = last_col && last_row;
    assign meta_in.row      = row_reg;
    assign meta_in.col      = COL_W'(col_reg);

    // room for every pixel in flight plus the queue contents
    assign inflight = fifo_count + FIFO_CNT_W'(s1_valid_reg) + FIFO_CNT_W'(s2_valid_reg)
                    + FIFO_CNT_W'(s3_valid_reg);
    assign pixels.ready = (inflight < FIFO_CNT_W'(FIFO_DEPTH));
    assign accept       = pixels.valid && pixels.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: height_reg <= cfg_wdata;
            endcase
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_reg <= col_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pixels.data.pixel_in;
            s1_addr_reg <= col_reg;
            s1_meta_reg <= meta_in;
        end
        s2_pix_reg  <= s1_pix_reg;
        s2_meta_reg <= s1_meta_reg;
        s3_pix_reg  <= s2_pix_reg;
        s3_meta_reg <= s2_meta_reg;
    end

    // older line takes the newer line's pixel, newer line takes the new pixel
    bb3_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data ({up1, s1_pix_reg}),
        .rd_data (line_rd)
    );

    assign up2 = line_rd[LINE_W-1:PIX_W];
    assign up1 = line_rd[PIX_W-1:0];

    bb3_window u_window (
        .clk      (clk),
        .shift_en (s1_valid_reg),
        .up2      (up2),
        .up1      (up1),
        .pix      (s1_pix_reg),
        .mean     (mean)
    );

    assign push            = s3_valid_reg && (s3_meta_reg.has_int || s3_meta_reg.has_bord);
    assign push_entry.meta = s3_meta_reg;
    assign push_entry.mean = mean;
    assign push_entry.pix  = s3_pix_reg;

    bb3_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .count      (fifo_count),
        .results    (results)
    );

endmodule

// File: hw/rtl/bb3_checker.sv
// port-level checks of the box blur results channel, bound to the top level
module bb3_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             res_valid,
    input logic             res_ready,
    input bb3_pkg::result_t res_data
);
    import bb3_pkg::*;

    // the frame ends only on the last result of a pixel
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.frame_done |-> res_data.last_of_item)
        else $error("frame_done without last_of_item");

    // a result that is not last is an interior mean, never on row or column 0
    a_interior_coords: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.last_of_item |-> res_data.out_row != '0 && res_data.out_col != '0)
        else $error("interior result on the border");

    // the border result of the same pixel follows an interior transfer at once
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_data.last_of_item |=> res_valid && res_data.last_of_item)
        else $error("second result of a pixel missing");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

endmodule

bind box_blur_3x3_core bb3_checker u_bb3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_data  (results.data)
);

// File: tb/tb.sv
// self-checking testbench of the streaming 3x3 box blur core
`timescale 1ns / 1ps

module tb;

    import bb3_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 900;
    localparam int EDGE_ITEMS   = 160;
    localparam int PRINT_LIMIT  = 40;

    typedef enum int {
        PIX_RANDOM,
        PIX_EXTREME,
        PIX_BRIGHT,
        PIX_DARK
    } pix_style_t;

    // predicts the result stream from accepted pixels and checks it in order
    class blur_scoreboard;

        localparam int unsigned WINDOW_AREA = 9;

        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        logic [PIX_W-1:0] row_older [MAX_WIDTH_DEF];
        logic [PIX_W-1:0] row_newer [MAX_WIDTH_DEF];
        logic [PIX_W-1:0] win [9];
        int unsigned      at_row;
        int unsigned      at_col;
        result_t          pending [$];
        int               errors;
        int               pixels_taken;
        int               interior_made;
        int               border_made;
        int               frames_done;

        function new();
            width_reg  = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            foreach (row_older[i])
            begin
                row_older[i] = '0;
                row_newer[i] = '0;
            end
            foreach (win[i])
            begin
                win[i] = '0;
            end
            at_row = 0;
            at_col = 0;
        endfunction

        function int unsigned eff_width();
            int unsigned w;
            w = width_reg;
            if (w == 0)
            begin
                w = 1;
            end
            if (w > MAX_WIDTH_DEF)
            begin
                w = MAX_WIDTH_DEF;
            end
            return w;
        endfunction

        function int unsigned eff_height();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        // any register write restarts the frame
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_FRAME_WIDTH:  width_reg  = value;
                REG_FRAME_HEIGHT: height_reg = value;
                default: ;
            endcase
            at_row = 0;
            at_col = 0;
        endfunction

        function void take_pixel(logic [PIX_W-1:0] p);
            int unsigned      w;
            int unsigned      h;
            int unsigned      sum;
            int               first;
            logic [PIX_W-1:0] up2;
            logic [PIX_W-1:0] up1;
            result_t          res;
            w = eff_width();
            h = eff_height();
            up2 = row_older[at_col];
            up1 = row_newer[at_col];
            row_older[at_col] = up1;
            row_newer[at_col] = p;
            for (int i = 0; i < 3; i++)
            begin
                win[i * 3]     = win[i * 3 + 1];
                win[i * 3 + 1] = win[i * 3 + 2];
            end
            win[2] = up2;
            win[5] = up1;
            win[8] = p;
            first = pending.size();
            if (at_row >= 2 && at_col >= 2)
            begin
                sum = 0;
                foreach (win[i])
                begin
                    sum += win[i];
                end
                res.pixel_out    = PIX_W'(sum / WINDOW_AREA);
                res.out_row      = ROW_W'(at_row - 1);
                res.out_col      = COL_W'(at_col - 1);
                res.last_of_item = 1'b0;
                res.frame_done   = 1'b0;
                pending.push_back(res);
                interior_made++;
            end
            if (at_row == 0 || at_col == 0 || at_row + 1 == h || at_col + 1 == w)
            begin
                res.pixel_out    = p;
                res.out_row      = ROW_W'(at_row);
                res.out_col      = COL_W'(at_col);
                res.last_of_item = 1'b0;
                res.frame_done   = 1'b0;
                pending.push_back(res);
                border_made++;
            end
            if (pending.size() > first)
            begin
                pending[pending.size() - 1].last_of_item = 1'b1;
            end
            if (at_col + 1 >= w)
            begin
                at_col = 0;
                if (at_row + 1 >= h)
                begin
                    at_row = 0;
                    frames_done++;
                    if (pending.size() > first)
                    begin
                        pending[pending.size() - 1].frame_done = 1'b1;
                    end
                end
                else
                begin
                    at_row++;
                end
            end
            else
            begin
                at_col++;
            end
            pixels_taken++;
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT)
            begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
            errors++;
        endtask

        task match_output(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("result with nothing pending: row %0d col %0d pixel %0d",
                                 got.out_row, got.out_col, got.pixel_out));
                return;
            end
            want = pending.pop_front();
            if (got.pixel_out !== want.pixel_out)
            begin
                report($sformatf("pixel_out %0d, want %0d at (%0d,%0d)",
                                 got.pixel_out, want.pixel_out, want.out_row, want.out_col));
            end
            if (got.out_row !== want.out_row)
            begin
                report($sformatf("out_row %0d, want %0d", got.out_row, want.out_row));
            end
            if (got.out_col !== want.out_col)
            begin
                report($sformatf("out_col %0d, want %0d", got.out_col, want.out_col));
            end
            if (got.last_of_item !== want.last_of_item)
            begin
                report($sformatf("last_of_item %b, want %b at (%0d,%0d)",
                                 got.last_of_item, want.last_of_item,
                                 want.out_row, want.out_col));
            end
            if (got.frame_done !== want.frame_done)
            begin
                report($sformatf("frame_done %b, want %b at (%0d,%0d)",
                                 got.frame_done, want.frame_done,
                                 want.out_row, want.out_col));
            end
        endtask

    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    bb3_stream_if #(.payload_t(pixel_t))  pixel_ch ();
    bb3_stream_if #(.payload_t(result_t)) result_ch ();

    box_blur_3x3_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pixels    (pixel_ch),
        .results   (result_ch)
    );

    blur_scoreboard sb = new();
    bit             steady;
    bit             hold_request;
    int             settings_used;

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_500_000;
        $display("run timed out with %0d results pending", sb.pending.size());
        $display("TEST FAILED");
        $finish;
    end

    // receiver side: random stalls, one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (steady)
            begin
                result_ch.ready <= 1'b1;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= 8);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            sb.match_output(result_ch.data);
        end
    end

    function automatic logic [PIX_W-1:0] pick_pixel(pix_style_t style);
        case (style)
            PIX_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
            PIX_BRIGHT:  return 8'hFF;
            PIX_DARK:    return PIX_W'($urandom_range(3));
            default:     return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // let results drain, then a few more cycles for pixels that make no result
    task automatic wait_idle();
        while (sb.pending.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input logic [1:0] which);
        wait_idle();
        if (which[0])
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_FRAME_WIDTH;
            cfg_wdata <= w;
            sb.write_reg(REG_FRAME_WIDTH, w);
            @(negedge clk);
        end
        if (which[1])
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_FRAME_HEIGHT;
            cfg_wdata <= h;
            sb.write_reg(REG_FRAME_HEIGHT, h);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_pixel(input logic [PIX_W-1:0] p);
        while (!steady && $urandom_range(99) < 8)
        begin
            pixel_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pixel_ch.valid <= 1'b1;
        pixel_ch.data.pixel_in <= p;
        @(posedge clk);
        while (!pixel_ch.ready)
        begin
            @(posedge clk);
        end
        sb.take_pixel(p);
        @(negedge clk);
    endtask

    task automatic send_run(input int count, input pix_style_t style);
        repeat (count) send_pixel(pick_pixel(style));
        pixel_ch.valid <= 1'b0;
    endtask

    initial
    begin
        logic [PIX_W-1:0] opening [4];
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        logic [1:0]       which;
        pix_style_t       style;
        int               fed;
        int               phase;
        int               pick;
        int               area;
        int               count;
        int               waited;

        cfg_we = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_wdata = '0;
        pixel_ch.valid = 1'b0;
        pixel_ch.data = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset sizes: first row is all border
        opening = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
        foreach (opening[i])
        begin
            send_pixel(opening[i]);
        end
        pixel_ch.valid <= 1'b0;

        // smallest frame with an interior pixel, largest possible sum
        set_size(12'd3, 12'd3, 2'b11);
        send_run(9, PIX_BRIGHT);
        // zero sizes act as one
        set_size(12'd0, 12'd0, 2'b11);
        send_run(2, PIX_EXTREME);
        // narrow frame, then a height write restarts it mid-frame
        set_size(12'd2, 12'd5, 2'b11);
        send_run(3, PIX_RANDOM);
        set_size(12'd0, 12'd3, 2'b10);
        send_run(3, PIX_RANDOM);
        // width above the line store clamps
        set_size(12'd3000, 12'd3, 2'b11);
        send_run(4, PIX_RANDOM);

        // extreme sizes: the start of the widest row and of the tallest column
        set_size(12'd4095, 12'd1, 2'b11);
        send_run(EDGE_ITEMS, PIX_RANDOM);
        set_size(12'd1, 12'd4095, 2'b11);
        send_run(EDGE_ITEMS, PIX_RANDOM);

        fed = 0;
        phase = 0;
        while (fed < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                w = CFG_W'($urandom_range(1, 12));
                h = CFG_W'($urandom_range(1, 10));
            end
            else if (pick < 80)
            begin
                w = CFG_W'($urandom_range(13, 90));
                h = CFG_W'($urandom_range(1, 6));
            end
            else if (pick < 90)
            begin
                w = CFG_W'($urandom_range(0, 3));
                h = CFG_W'($urandom_range(0, 3));
            end
            else if (pick < 95)
            begin
                w = CFG_W'($urandom_range(1, 6));
                h = CFG_W'($urandom_range(100, 4095));
            end
            else
            begin
                w = CFG_W'($urandom_range(2049, 4095));
                h = CFG_W'($urandom_range(1, 4095));
            end
            which = ($urandom_range(9) == 0) ? 2'($urandom_range(1, 2)) : 2'b11;
            if (phase == 2 || phase == 4)
            begin
                w = (phase == 2) ? 12'd8 : 12'd16;
                h = (phase == 2) ? 12'd8 : 12'd12;
                which = 2'b11;
            end
            set_size(w, h, which);
            area = int'(sb.eff_width() * sb.eff_height());
            if (phase == 2 || phase == 4)
            begin
                count = area;
            end
            else if ($urandom_range(99) < 60 && area <= 240)
            begin
                count = area * $urandom_range(1, 2);
            end
            else
            begin
                count = $urandom_range(1, (area < 75) ? area * 2 : 150);
            end
            style = ($urandom_range(9) < 6) ? PIX_RANDOM : pix_style_t'($urandom_range(3));
            // receiver holds off while this frame streams in, so the block backs up
            if (phase == 2)
            begin
                hold_request = 1'b1;
            end
            steady = (phase == 4);
            send_run(count, style);
            steady = 1'b0;
            fed += count;
            phase++;
        end

        waited = 0;
        while (sb.pending.size() != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (4 * DRAIN_CYCLES) @(negedge clk);
        if (sb.pending.size() != 0)
        begin
            sb.report($sformatf("%0d expected results never arrived", sb.pending.size()));
        end

        $display("streamed %0d pixels under %0d size settings, widths 1..2048, heights 1..4095",
                 sb.pixels_taken, settings_used);
        $display("compared %0d window means and %0d border pixels, %0d frames completed",
                 sb.interior_made, sb.border_made, sb.frames_done);
        if (sb.errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
